// ===== design/bpcr_pkg.sv =====
// Package for the ball pair collision resolver.
// Holds the widths, the context record that runs beside the arithmetic and the saturation helper.
// No dependencies.
package bpcr_pkg;

	// field widths
	localparam int CW   = 24;          // coordinates and velocities, signed Q15.8
	localparam int SW   = 16;          // radius, unsigned Q8.8

	// derived widths
	localparam int DW   = CW + 1;      // centre and velocity differences
	localparam int PW   = 2 * DW;      // one product of two differences
	localparam int D2W  = PW;          // squared centre distance
	localparam int SQ_N = DW;          // root bits, one per square root stage
	localparam int SUMW = SW + 1;      // sum of radii
	localparam int OVW  = DW + 1;      // signed overlap
	localparam int DOTW = PW + 1;      // normal relative velocity, unscaled
	localparam int QW   = CW + 4;      // quotient magnitude bits
	localparam int NW   = PW + 3;      // signed dividend
	localparam int VW   = DW + 1;      // divisor
	localparam int RW   = NW + 1;      // divider partial remainder
	localparam int SATW = QW + 2;      // sum ahead of saturation
	localparam int DIV_LAT = QW + 2;   // divider latency in cycles

	// everything one transaction carries down the pipe
	typedef struct packed {
		logic signed [CW-1:0]   a_px;
		logic signed [CW-1:0]   a_py;
		logic signed [CW-1:0]   a_vx;
		logic signed [CW-1:0]   a_vy;
		logic signed [CW-1:0]   b_px;
		logic signed [CW-1:0]   b_py;
		logic signed [CW-1:0]   b_vx;
		logic signed [CW-1:0]   b_vy;
		logic [SW-1:0]          ra;
		logic [SW-1:0]          rb;
		logic [SUMW-1:0]        sum;
		logic signed [DW-1:0]   dx;
		logic signed [DW-1:0]   dy;
		logic signed [DOTW-1:0] dot;
		logic [SQ_N-1:0]        span;
		logic                   coin;
		logic                   ovlp;
		logic                   apart;
	} ctx_t;

	// clamp to the coordinate range
	function automatic logic signed [CW-1:0] sat_c(input logic signed [SATW-1:0] x);
		logic signed [SATW-1:0] hi;
		logic signed [SATW-1:0] lo;
		hi = {{(SATW-CW+1){1'b0}}, {(CW-1){1'b1}}};
		lo = ~hi;
		if (x > hi)
			return hi[CW-1:0];
		if (x < lo)
			return lo[CW-1:0];
		return x[CW-1:0];
	endfunction

endpackage

// ===== design/bpcr_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, floor result.
// Carries the transaction context and valid bit alongside. Depends on bpcr_pkg.
module bpcr_sqrt
	import bpcr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             v_in,
	input  logic [D2W-1:0]   d2,
	input  ctx_t             ctx_in,
	output logic             v_out,
	output logic [SQ_N-1:0]  root,
	output ctx_t             ctx_out
);
	localparam int RTW = D2W + 1;

	logic [SQ_N-1:0] v_s;
	logic [RTW-1:0]  rem_s  [SQ_N];
	logic [SQ_N-1:0] root_s [SQ_N];
	ctx_t            ctx_s  [SQ_N];
	logic [RTW-1:0]  rem_in  [SQ_N];
	logic [SQ_N-1:0] root_in [SQ_N];
	logic [RTW-1:0]  trial   [SQ_N];

	// stage inputs and trial subtrahends
	always_comb begin
		rem_in[0]  = RTW'(d2);
		root_in[0] = '0;
		for (int k = 1; k < SQ_N; k++) begin
			rem_in[k]  = rem_s[k-1];
			root_in[k] = root_s[k-1];
		end
		for (int k = 0; k < SQ_N; k++)
			trial[k] = (RTW'(root_in[k]) << (SQ_N - k)) | (RTW'(1) << (2 * (SQ_N - 1 - k)));
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else if (en)
			v_s <= {v_s[SQ_N-2:0], v_in};
	end

	// one root bit a stage
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < SQ_N; k++) begin
				if (rem_in[k] >= trial[k]) begin
					rem_s[k]  <= rem_in[k] - trial[k];
					root_s[k] <= root_in[k] | (SQ_N'(1) << (SQ_N - 1 - k));
				end else begin
					rem_s[k]  <= rem_in[k];
					root_s[k] <= root_in[k];
				end
				ctx_s[k] <= (k == 0) ? ctx_in : ctx_s[(k == 0) ? 0 : k-1];
			end
		end
	end

	assign v_out   = v_s[SQ_N-1];
	assign root    = root_s[SQ_N-1];
	assign ctx_out = ctx_s[SQ_N-1];

	// floor root: remainder never reaches 2*root+1
	a_root_floor: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[SQ_N-1] |-> rem_s[SQ_N-1] <= RTW'({root_s[SQ_N-1], 1'b0}))
		else $error("square root remainder out of range");

endmodule

// ===== design/bpcr_div.sv =====
// Pipelined signed by unsigned divider, truncating toward zero, one quotient bit per stage.
// Quotient magnitude must fit QW bits. Depends on bpcr_pkg.
module bpcr_div
	import bpcr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic signed [NW-1:0] num,
	input  logic [VW-1:0]        den,
	output logic signed [QW:0]   quo
);
	logic [NW-1:0]       mag;
	logic [RW-1:0]       rem_s [QW+1];
	logic [VW-1:0]       den_s [QW+1];
	logic [QW-1:0]       q_s   [QW+1];
	logic [QW:0]         neg_s;
	logic [RW-1:0]       trial [QW+1];
	logic signed [QW:0]  quo_s;

	assign mag = num[NW-1] ? NW'(-num) : NW'(num);

	// shifted divisor for each stage
	always_comb begin
		trial[0] = '0;
		for (int k = 1; k <= QW; k++)
			trial[k] = RW'(den_s[k-1]) << (QW - k);
	end

	// magnitude stage, bit stages, sign stage
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= RW'(mag);
			den_s[0] <= den;
			q_s[0]   <= '0;
			neg_s[0] <= num[NW-1];
			for (int k = 1; k <= QW; k++) begin
				if (rem_s[k-1] >= trial[k]) begin
					rem_s[k] <= rem_s[k-1] - trial[k];
					q_s[k]   <= q_s[k-1] | (QW'(1) << (QW - k));
				end else begin
					rem_s[k] <= rem_s[k-1];
					q_s[k]   <= q_s[k-1];
				end
				den_s[k] <= den_s[k-1];
				neg_s[k] <= neg_s[k-1];
			end
			quo_s <= neg_s[QW] ? -$signed({1'b0, q_s[QW]}) : $signed({1'b0, q_s[QW]});
		end
	end

	assign quo = quo_s;

	// quotient range held: the last remainder is below the divisor
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		den_s[QW] != '0 |-> rem_s[QW] < RW'(den_s[QW]))
		else $error("divider quotient overflow");

endmodule

// ===== design/bpcr_ctxdly.sv =====
// Delay line for the transaction context and valid bit, matched to divider latency.
// Depends on bpcr_pkg.
module bpcr_ctxdly
	import bpcr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic v_in,
	input  ctx_t ctx_in,
	output logic v_out,
	output ctx_t ctx_out
);
	logic [DIV_LAT-1:0] v_s;
	ctx_t               ctx_s [DIV_LAT];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else if (en)
			v_s <= {v_s[DIV_LAT-2:0], v_in};
	end

	// context taps
	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s[0] <= ctx_in;
			for (int k = 1; k < DIV_LAT; k++)
				ctx_s[k] <= ctx_s[k-1];
		end
	end

	assign v_out   = v_s[DIV_LAT-1];
	assign ctx_out = ctx_s[DIV_LAT-1];

endmodule

// ===== design/ball_pair_collision_resolver.sv =====
// Channel  | handshake           | payload
// input    | in_valid / in_ready | a_*, b_* ball state, 10 fields
// output   | out_valid/out_ready | new_a_*, new_b_*, overlapping, coincident, moving_apart
//
// One transaction per cycle unless the output blocks. Stages: 3 front stages, 25 square root
// stages, 2 stages, three divider passes with one stage between, output register.
// The divider chain (distance, then sum of radii, then distance again) sets the latency.
// Reset clears valid bits only. When a result waits at the output, the whole pipe holds.
// Top level: depends on bpcr_pkg, bpcr_sqrt, bpcr_div, bpcr_ctxdly.
module ball_pair_collision_resolver
	import bpcr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [CW-1:0] a_pos_x,
	input  logic signed [CW-1:0] a_pos_y,
	input  logic signed [CW-1:0] a_vel_x,
	input  logic signed [CW-1:0] a_vel_y,
	input  logic [SW-1:0]        a_size,
	input  logic signed [CW-1:0] b_pos_x,
	input  logic signed [CW-1:0] b_pos_y,
	input  logic signed [CW-1:0] b_vel_x,
	input  logic signed [CW-1:0] b_vel_y,
	input  logic [SW-1:0]        b_size,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [CW-1:0] new_a_pos_x,
	output logic signed [CW-1:0] new_a_pos_y,
	output logic signed [CW-1:0] new_a_vel_x,
	output logic signed [CW-1:0] new_a_vel_y,
	output logic signed [CW-1:0] new_b_pos_x,
	output logic signed [CW-1:0] new_b_pos_y,
	output logic signed [CW-1:0] new_b_vel_x,
	output logic signed [CW-1:0] new_b_vel_y,
	output logic                 overlapping,
	output logic                 coincident,
	output logic                 moving_apart
);
	logic en;

	// front stages
	ctx_t                   ctx_in, ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s6, ctx_s7;
	ctx_t                   ctx_n2, ctx_n3, ctx_n4, ctx_n6;
	logic                   v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic signed [DW-1:0]   rvx_s1, rvy_s1;
	logic signed [PW-1:0]   sqx_s2, sqy_s2, pdx_s2, pdy_s2;
	logic [D2W-1:0]         d2_s3;

	// square root
	logic                   sq_v;
	logic [SQ_N-1:0]        sq_dist;
	ctx_t                   sq_ctx;
	logic signed [OVW-1:0]  ovl_s4;

	// first divider pass
	ctx_t                   ctx_s5, d1_ctx;
	logic                   d1_v;
	logic signed [DW+OVW-1:0] sxp, syp;
	logic signed [NW-1:0]   sxn_s5, syn_s5, dotn_s5;
	logic [VW-1:0]          den2_s5, den1_s5;
	logic signed [QW:0]     sx_q, sy_q, van_q;

	// second divider pass
	logic                   d2_v;
	ctx_t                   d2_ctx;
	logic signed [QW+SW+2:0] nap, nbp;
	logic signed [NW-1:0]   nan_s6, nbn_s6;
	logic [VW-1:0]          sden_s6;
	logic signed [QW:0]     ka_q, kb_q;

	// third divider pass
	logic                   d3_v;
	ctx_t                   d3_ctx;
	logic signed [QW+DW:0]  kax, kay, kbx, kby;
	logic signed [NW-1:0]   kax_s7, kay_s7, kbx_s7, kby_s7;
	logic [VW-1:0]          dden_s7;
	logic signed [QW:0]     qax_q, qay_q, qbx_q, qby_q;
	logic                   upd;

	// output register
	logic                   v_s8;

	assign en       = !v_s8 || out_ready;
	assign in_ready = en;

	// valid bits of the top level stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= sq_v;
			v_s5 <= v_s4;
			v_s6 <= d1_v;
			v_s7 <= d2_v;
			v_s8 <= d3_v;
		end
	end

	// stage 1: capture, centre and velocity differences
	always_comb begin
		ctx_in      = '0;
		ctx_in.a_px = a_pos_x;
		ctx_in.a_py = a_pos_y;
		ctx_in.a_vx = a_vel_x;
		ctx_in.a_vy = a_vel_y;
		ctx_in.b_px = b_pos_x;
		ctx_in.b_py = b_pos_y;
		ctx_in.b_vx = b_vel_x;
		ctx_in.b_vy = b_vel_y;
		ctx_in.ra   = a_size;
		ctx_in.rb   = b_size;
		ctx_in.dx   = DW'(b_pos_x) - DW'(a_pos_x);
		ctx_in.dy   = DW'(b_pos_y) - DW'(a_pos_y);
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			ctx_s1 <= ctx_in;
			rvx_s1 <= DW'(b_vel_x) - DW'(a_vel_x);
			rvy_s1 <= DW'(b_vel_y) - DW'(a_vel_y);
		end
	end

	// stage 2: squares, velocity products, radius sum and coincidence flag
	always_comb begin
		ctx_n2      = ctx_s1;
		ctx_n2.sum  = SUMW'(ctx_s1.ra) + SUMW'(ctx_s1.rb);
		ctx_n2.coin = (ctx_s1.dx == '0) && (ctx_s1.dy == '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s2 <= ctx_n2;
			sqx_s2 <= $signed(ctx_s1.dx) * $signed(ctx_s1.dx);
			sqy_s2 <= $signed(ctx_s1.dy) * $signed(ctx_s1.dy);
			pdx_s2 <= rvx_s1 * $signed(ctx_s1.dx);
			pdy_s2 <= rvy_s1 * $signed(ctx_s1.dy);
		end
	end

	// stage 3: squared distance and dot product
	always_comb begin
		ctx_n3     = ctx_s2;
		ctx_n3.dot = DOTW'(pdx_s2) + DOTW'(pdy_s2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s3 <= ctx_n3;
			d2_s3  <= D2W'($unsigned(sqx_s2) + $unsigned(sqy_s2));
		end
	end

	bpcr_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (v_s3),
		.d2      (d2_s3),
		.ctx_in  (ctx_s3),
		.v_out   (sq_v),
		.root    (sq_dist),
		.ctx_out (sq_ctx)
	);

	// stage 4: overlap and flags
	always_comb begin
		ctx_n4       = sq_ctx;
		ctx_n4.span  = sq_dist;
		ctx_n4.ovlp  = DW'(sq_dist) < DW'(sq_ctx.sum);
		ctx_n4.apart = !sq_ctx.coin && ($signed(sq_ctx.dot) > 0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s4 <= ctx_n4;
			ovl_s4 <= $signed(OVW'(sq_ctx.sum)) - $signed(OVW'(sq_dist));
		end
	end

	// stage 5: separation numerators
	assign sxp = $signed(ctx_s4.dx) * ovl_s4;
	assign syp = $signed(ctx_s4.dy) * ovl_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s5  <= ctx_s4;
			sxn_s5  <= NW'(sxp);
			syn_s5  <= NW'(syp);
			dotn_s5 <= NW'($signed(ctx_s4.dot));
			den2_s5 <= VW'({ctx_s4.span, 1'b0});
			den1_s5 <= VW'(ctx_s4.span);
		end
	end

	bpcr_div u_div_sx (.clk(clk), .arst_n(arst_n), .en(en), .num(sxn_s5), .den(den2_s5),
		.quo(sx_q));
	bpcr_div u_div_sy (.clk(clk), .arst_n(arst_n), .en(en), .num(syn_s5), .den(den2_s5),
		.quo(sy_q));
	bpcr_div u_div_van (.clk(clk), .arst_n(arst_n), .en(en), .num(dotn_s5), .den(den1_s5),
		.quo(van_q));
	bpcr_ctxdly u_cd1 (.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_s5), .ctx_in(ctx_s5),
		.v_out(d1_v), .ctx_out(d1_ctx));

	// stage 6: new positions and impulse numerators
	assign nap = (van_q * $signed({1'b0, d1_ctx.rb})) <<< 1;
	assign nbp = (van_q * $signed({1'b0, d1_ctx.ra})) <<< 1;

	always_comb begin
		ctx_n6 = d1_ctx;
		if (!d1_ctx.coin) begin
			ctx_n6.a_px = sat_c(SATW'(d1_ctx.a_px) - SATW'(sx_q));
			ctx_n6.a_py = sat_c(SATW'(d1_ctx.a_py) - SATW'(sy_q));
			ctx_n6.b_px = sat_c(SATW'(d1_ctx.b_px) + SATW'(sx_q));
			ctx_n6.b_py = sat_c(SATW'(d1_ctx.b_py) + SATW'(sy_q));
		end
	end

	// coincident centres leave van undefined, so its numerators are zeroed
	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s6  <= ctx_n6;
			nan_s6  <= d1_ctx.coin ? '0 : NW'(nap);
			nbn_s6  <= d1_ctx.coin ? '0 : NW'(nbp);
			sden_s6 <= VW'(d1_ctx.sum);
		end
	end

	bpcr_div u_div_ka (.clk(clk), .arst_n(arst_n), .en(en), .num(nan_s6), .den(sden_s6),
		.quo(ka_q));
	bpcr_div u_div_kb (.clk(clk), .arst_n(arst_n), .en(en), .num(nbn_s6), .den(sden_s6),
		.quo(kb_q));
	bpcr_ctxdly u_cd2 (.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_s6), .ctx_in(ctx_s6),
		.v_out(d2_v), .ctx_out(d2_ctx));

	// stage 7: impulse components along the normal
	assign kax = ka_q * $signed(d2_ctx.dx);
	assign kay = ka_q * $signed(d2_ctx.dy);
	assign kbx = kb_q * $signed(d2_ctx.dx);
	assign kby = kb_q * $signed(d2_ctx.dy);

	// a zero radius sum leaves ka and kb undefined, so the numerators are zeroed
	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s7  <= d2_ctx;
			kax_s7  <= (d2_ctx.sum == '0) ? '0 : NW'(kax);
			kay_s7  <= (d2_ctx.sum == '0) ? '0 : NW'(kay);
			kbx_s7  <= (d2_ctx.sum == '0) ? '0 : NW'(kbx);
			kby_s7  <= (d2_ctx.sum == '0) ? '0 : NW'(kby);
			dden_s7 <= VW'(d2_ctx.span);
		end
	end

	bpcr_div u_div_ax (.clk(clk), .arst_n(arst_n), .en(en), .num(kax_s7), .den(dden_s7),
		.quo(qax_q));
	bpcr_div u_div_ay (.clk(clk), .arst_n(arst_n), .en(en), .num(kay_s7), .den(dden_s7),
		.quo(qay_q));
	bpcr_div u_div_bx (.clk(clk), .arst_n(arst_n), .en(en), .num(kbx_s7), .den(dden_s7),
		.quo(qbx_q));
	bpcr_div u_div_by (.clk(clk), .arst_n(arst_n), .en(en), .num(kby_s7), .den(dden_s7),
		.quo(qby_q));
	bpcr_ctxdly u_cd3 (.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_s7), .ctx_in(ctx_s7),
		.v_out(d3_v), .ctx_out(d3_ctx));

	// stage 8: velocity update and output register
	assign upd = !d3_ctx.coin && !d3_ctx.apart && (d3_ctx.sum != '0);

	always_ff @(posedge clk) begin
		if (en) begin
			new_a_pos_x  <= d3_ctx.a_px;
			new_a_pos_y  <= d3_ctx.a_py;
			new_b_pos_x  <= d3_ctx.b_px;
			new_b_pos_y  <= d3_ctx.b_py;
			new_a_vel_x  <= upd ? sat_c(SATW'(d3_ctx.a_vx) + SATW'(qax_q)) : d3_ctx.a_vx;
			new_a_vel_y  <= upd ? sat_c(SATW'(d3_ctx.a_vy) + SATW'(qay_q)) : d3_ctx.a_vy;
			new_b_vel_x  <= upd ? sat_c(SATW'(d3_ctx.b_vx) - SATW'(qbx_q)) : d3_ctx.b_vx;
			new_b_vel_y  <= upd ? sat_c(SATW'(d3_ctx.b_vy) - SATW'(qby_q)) : d3_ctx.b_vy;
			overlapping  <= d3_ctx.ovlp;
			coincident   <= d3_ctx.coin;
			moving_apart <= d3_ctx.apart;
		end
	end

	assign out_valid = v_s8;

	// coincident centres never report separation
	a_coin_apart: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(coincident && moving_apart))
		else $error("coincident result flagged as moving apart");

	// a blocked result holds the input side in the same cycle
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("pipeline advanced while output blocked");

endmodule
